// ===== src/sce_pkg.sv =====
package sce_pkg;

	localparam int NUM_COEF        = 8;
	localparam int COEF_IDX_W      = $clog2(NUM_COEF);
	localparam int CFG_IDX_W       = 4;
	localparam int COEF_W          = 64;
	localparam int DIST_W          = 32;
	localparam int GAM_W           = 40;
	localparam int ETA_W           = 48;
	localparam int VAL_W           = 64;
	localparam int ROOT_W          = 37;
	localparam int QUO_W           = 64;
	localparam int TAPER_TERMS_DEF = 8;

	localparam int ROOT_LAT = 3 + 2 * ROOT_W;
	localparam int DIV_LAT  = 4 + QUO_W + 1;

	localparam logic CMD_DIAG = 1'b0;
	localparam logic CMD_PAIR = 1'b1;

	localparam logic [63:0] K_Q60    = 64'hE666_6666_6666_6666;
	localparam logic [63:0] COEF_ONE = 64'h0001_0000_0000_0000;
	localparam logic [63:0] SMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SMIN     = 64'h8000_0000_0000_0000;

	typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_bank_t;

	typedef struct packed {
		logic              vld;
		logic              sat;
		logic [COEF_W-1:0] val;
	} tap_t;

	typedef struct packed {
		logic             vld;
		logic             cmd;
		logic [ETA_W-1:0] eta;
	} tag_t;

endpackage

// ===== src/sce_taper.sv =====
module sce_taper import sce_pkg::*; #(
	parameter int TERMS = TAPER_TERMS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [DIST_W-1:0] r,
	input  coef_bank_t        coef,
	output tap_t              tap
);

	localparam int STEPS = TERMS - 1;
	localparam logic [96:0] HALF = 97'd1 << 27;

	logic              vld_s1 [STEPS];
	logic              neg_s1 [STEPS];
	logic              sat_s1 [STEPS];
	logic [COEF_W-1:0] mag_s1 [STEPS];
	logic [DIST_W-1:0] r_s1   [STEPS];

	logic              vld_s2 [STEPS];
	logic              neg_s2 [STEPS];
	logic              sat_s2 [STEPS];
	logic [63:0]       pl_s2  [STEPS];
	logic [63:0]       ph_s2  [STEPS];
	logic [DIST_W-1:0] r_s2   [STEPS];

	logic              vld_s3 [STEPS];
	logic              sat_s3 [STEPS];
	logic [COEF_W-1:0] tp_s3  [STEPS];
	logic [DIST_W-1:0] r_s3   [STEPS];

	logic              vld_s4 [STEPS];
	logic              sat_s4 [STEPS];
	logic [COEF_W-1:0] acc_s4 [STEPS];
	logic [DIST_W-1:0] r_s4   [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int CI = TERMS - 2 - k;
		logic              v_in;
		logic              sat_in;
		logic [COEF_W-1:0] acc_in;
		logic [DIST_W-1:0] r_in;
		logic [96:0]       prod;
		logic [68:0]       pm;
		logic              pov;
		logic [COEF_W-1:0] pk;
		logic [COEF_W-1:0] sum;
		logic              aov;

		if (k == 0) begin : g_first
			assign v_in   = in_vld;
			assign sat_in = 1'b0;
			assign acc_in = coef[TERMS-1];
			assign r_in   = r;
		end else begin : g_next
			assign v_in   = vld_s4[k-1];
			assign sat_in = sat_s4[k-1];
			assign acc_in = acc_s4[k-1];
			assign r_in   = r_s4[k-1];
		end

		always_comb begin
			prod = {1'b0, ph_s2[k], 32'b0} + 97'(pl_s2[k]) + HALF;
			pm   = prod[96:28];
			if (neg_s2[k]) begin
				pov = (|pm[68:64]) || (pm[63] && (|pm[62:0]));
				pk  = pov ? SMIN : -pm[63:0];
			end else begin
				pov = |pm[68:63];
				pk  = pov ? SMAX : pm[63:0];
			end
			sum = tp_s3[k] + coef[CI];
			aov = (tp_s3[k][63] == coef[CI][63]) && (sum[63] != tp_s3[k][63]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[k] <= 1'b0;
				vld_s2[k] <= 1'b0;
				vld_s3[k] <= 1'b0;
				vld_s4[k] <= 1'b0;
			end else begin
				vld_s1[k] <= v_in;
				vld_s2[k] <= vld_s1[k];
				vld_s3[k] <= vld_s2[k];
				vld_s4[k] <= vld_s3[k];
			end
		end

		always_ff @(posedge clk) begin
			neg_s1[k] <= acc_in[63];
			mag_s1[k] <= acc_in[63] ? -acc_in : acc_in;
			sat_s1[k] <= sat_in;
			r_s1[k]   <= r_in;

			neg_s2[k] <= neg_s1[k];
			pl_s2[k]  <= mag_s1[k][31:0] * r_s1[k];
			ph_s2[k]  <= mag_s1[k][63:32] * r_s1[k];
			sat_s2[k] <= sat_s1[k];
			r_s2[k]   <= r_s1[k];

			tp_s3[k]  <= pk;
			sat_s3[k] <= sat_s2[k] | pov;
			r_s3[k]   <= r_s2[k];

			acc_s4[k] <= aov ? (tp_s3[k][63] ? SMIN : SMAX) : sum;
			sat_s4[k] <= sat_s3[k] | aov;
			r_s4[k]   <= r_s3[k];
		end
	end

	assign tap.vld = vld_s4[STEPS-1];
	assign tap.sat = sat_s4[STEPS-1];
	assign tap.val = acc_s4[STEPS-1];

endmodule

// ===== src/sce_cbrt.sv =====
module sce_cbrt import sce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [DIST_W-1:0] r,
	input  logic [GAM_W-1:0]  gam,
	output logic              out_vld,
	output logic [ROOT_W-1:0] y
);

	localparam int XW = 110;
	localparam int CW = 112;
	localparam int SW = 2 * ROOT_W;

	logic              vld_s1;
	logic [63:0]       rr_s1;
	logic [DIST_W-1:0] r_s1;
	logic [GAM_W-1:0]  gam_s1;

	logic              vld_s2;
	logic [63:0]       lo_s2;
	logic [63:0]       hi_s2;
	logic [GAM_W-1:0]  gam_s2;

	logic              vld_s3;
	logic [XW-1:0]     x_s3;

	logic              vld_s4 [ROOT_W];
	logic [XW-1:0]     x_s4   [ROOT_W];
	logic [ROOT_W-1:0] y_s4   [ROOT_W];
	logic [SW-1:0]     y2_s4  [ROOT_W];
	logic [CW-1:0]     y3_s4  [ROOT_W];
	logic [SW-1:0]     t2_s4  [ROOT_W];
	logic [CW-1:0]     t3_s4  [ROOT_W];

	logic              vld_s5 [ROOT_W];
	logic [XW-1:0]     x_s5   [ROOT_W];
	logic [ROOT_W-1:0] y_s5   [ROOT_W];
	logic [SW-1:0]     y2_s5  [ROOT_W];
	logic [CW-1:0]     y3_s5  [ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		rr_s1  <= r * r;
		r_s1   <= r;
		gam_s1 <= gam;
		lo_s2  <= rr_s1[31:0] * r_s1;
		hi_s2  <= rr_s1[63:32] * r_s1;
		gam_s2 <= gam_s1;
		x_s3   <= (XW'({hi_s2, 32'b0} + 96'(lo_s2)) << 12) + (XW'(gam_s2) << 64);
	end

	// one root bit per pair of stages; square and cube kept incrementally
	for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
		localparam int B = ROOT_W - 1 - j;
		logic              v_in;
		logic [XW-1:0]     x_in;
		logic [ROOT_W-1:0] y_in;
		logic [SW-1:0]     y2_in;
		logic [CW-1:0]     y3_in;
		logic              take;

		if (j == 0) begin : g_first
			assign v_in  = vld_s3;
			assign x_in  = x_s3;
			assign y_in  = '0;
			assign y2_in = '0;
			assign y3_in = '0;
		end else begin : g_next
			assign v_in  = vld_s5[j-1];
			assign x_in  = x_s5[j-1];
			assign y_in  = y_s5[j-1];
			assign y2_in = y2_s5[j-1];
			assign y3_in = y3_s5[j-1];
		end

		assign take = t3_s4[j] <= CW'(x_s4[j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s4[j] <= 1'b0;
				vld_s5[j] <= 1'b0;
			end else begin
				vld_s4[j] <= v_in;
				vld_s5[j] <= vld_s4[j];
			end
		end

		always_ff @(posedge clk) begin
			x_s4[j]  <= x_in;
			y_s4[j]  <= y_in;
			y2_s4[j] <= y2_in;
			y3_s4[j] <= y3_in;
			t2_s4[j] <= y2_in + (SW'(y_in) << (B + 1)) + (SW'(1) << (2 * B));
			t3_s4[j] <= y3_in + (((CW'(y2_in) << 1) + CW'(y2_in)) << B)
				+ (((CW'(y_in) << 1) + CW'(y_in)) << (2 * B)) + (CW'(1) << (3 * B));

			x_s5[j]  <= x_s4[j];
			y_s5[j]  <= take ? (y_s4[j] | (ROOT_W'(1) << B)) : y_s4[j];
			y2_s5[j] <= take ? t2_s4[j] : y2_s4[j];
			y3_s5[j] <= take ? t3_s4[j] : y3_s4[j];
		end
	end

	assign out_vld = vld_s5[ROOT_W-1];
	assign y       = y_s5[ROOT_W-1];

endmodule

// ===== src/sce_div.sv =====
module sce_div import sce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  tap_t              tap_in,
	input  logic [ROOT_W-1:0] y,
	output logic              out_vld,
	output logic [VAL_W-1:0]  value,
	output logic              sat
);

	logic              vld_s1;
	logic              neg_s1;
	logic              sat_s1;
	logic [63:0]       mag_s1;
	logic [ROOT_W-1:0] y_s1;

	logic              vld_s2;
	logic              neg_s2;
	logic              sat_s2;
	logic [63:0]       ll_s2;
	logic [63:0]       lh_s2;
	logic [63:0]       hl_s2;
	logic [63:0]       hh_s2;
	logic [ROOT_W-1:0] y_s2;

	logic              vld_s3;
	logic              neg_s3;
	logic              sat_s3;
	logic [127:0]      num_s3;
	logic [ROOT_W-1:0] y_s3;

	logic              vld_s4;
	logic              neg_s4;
	logic              sat_s4;
	logic              over_s4;
	logic              yz_s4;
	logic [ROOT_W-1:0] rem_s4;
	logic [QUO_W-1:0]  nb_s4;
	logic [ROOT_W-1:0] y_s4;

	logic              vld_s5  [QUO_W];
	logic              neg_s5  [QUO_W];
	logic              sat_s5  [QUO_W];
	logic              over_s5 [QUO_W];
	logic              yz_s5   [QUO_W];
	logic [ROOT_W-1:0] rem_s5  [QUO_W];
	logic [QUO_W-1:0]  nb_s5   [QUO_W];
	logic [QUO_W-1:0]  q_s5    [QUO_W];
	logic [ROOT_W-1:0] y_s5    [QUO_W];

	logic [QUO_W-1:0]  qf;
	logic              negf;
	logic              pov;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= tap_in.vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			out_vld <= vld_s5[QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= tap_in.val[63];
		mag_s1  <= tap_in.val[63] ? -tap_in.val : tap_in.val;
		sat_s1  <= tap_in.sat;
		y_s1    <= y;

		neg_s2  <= neg_s1;
		sat_s2  <= sat_s1;
		y_s2    <= y_s1;
		ll_s2   <= mag_s1[31:0] * K_Q60[31:0];
		lh_s2   <= mag_s1[31:0] * K_Q60[63:32];
		hl_s2   <= mag_s1[63:32] * K_Q60[31:0];
		hh_s2   <= mag_s1[63:32] * K_Q60[63:32];

		neg_s3  <= neg_s2;
		sat_s3  <= sat_s2;
		y_s3    <= y_s2;
		num_s3  <= {hh_s2, 64'b0} + (128'(lh_s2) << 32) + (128'(hl_s2) << 32) + 128'(ll_s2);

		// quotient of 2^64 or more saturates either way
		neg_s4  <= neg_s3;
		sat_s4  <= sat_s3;
		y_s4    <= y_s3;
		over_s4 <= ROOT_W'(num_s3[127:100]) >= y_s3;
		yz_s4   <= y_s3 == '0;
		rem_s4  <= ROOT_W'(num_s3[127:100]);
		nb_s4   <= num_s3[99:36];
	end

	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		logic              v_in;
		logic              neg_in;
		logic              sat_in;
		logic              over_in;
		logic              yz_in;
		logic [ROOT_W-1:0] rem_in;
		logic [QUO_W-1:0]  nb_in;
		logic [QUO_W-1:0]  q_in;
		logic [ROOT_W-1:0] y_in;
		logic [ROOT_W:0]   sh;
		logic              ge;

		if (i == 0) begin : g_first
			assign v_in    = vld_s4;
			assign neg_in  = neg_s4;
			assign sat_in  = sat_s4;
			assign over_in = over_s4;
			assign yz_in   = yz_s4;
			assign rem_in  = rem_s4;
			assign nb_in   = nb_s4;
			assign q_in    = '0;
			assign y_in    = y_s4;
		end else begin : g_next
			assign v_in    = vld_s5[i-1];
			assign neg_in  = neg_s5[i-1];
			assign sat_in  = sat_s5[i-1];
			assign over_in = over_s5[i-1];
			assign yz_in   = yz_s5[i-1];
			assign rem_in  = rem_s5[i-1];
			assign nb_in   = nb_s5[i-1];
			assign q_in    = q_s5[i-1];
			assign y_in    = y_s5[i-1];
		end

		assign sh = {rem_in, nb_in[QUO_W-1]};
		assign ge = sh >= {1'b0, y_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s5[i] <= 1'b0;
			end else begin
				vld_s5[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			neg_s5[i]  <= neg_in;
			sat_s5[i]  <= sat_in;
			over_s5[i] <= over_in;
			yz_s5[i]   <= yz_in;
			y_s5[i]    <= y_in;
			nb_s5[i]   <= nb_in << 1;
			q_s5[i]    <= {q_in[QUO_W-2:0], ge};
			rem_s5[i]  <= ge ? ROOT_W'(sh - {1'b0, y_in}) : sh[ROOT_W-1:0];
		end
	end

	assign qf   = q_s5[QUO_W-1];
	assign negf = neg_s5[QUO_W-1];
	assign pov  = negf ? (qf[63] && (|qf[62:0])) : qf[63];

	always_ff @(posedge clk) begin
		if (yz_s5[QUO_W-1] || over_s5[QUO_W-1] || pov) begin
			value <= negf ? SMIN : SMAX;
			sat   <= 1'b1;
		end else begin
			value <= negf ? -qf : qf;
			sat   <= sat_s5[QUO_W-1];
		end
	end

endmodule

// ===== src/shielded_coulomb_matrix_entry.sv =====
// Path from an accepted start to done: the cube root, then the scaled divide, then one output register;
// the path is the same for both commands.
// Throughput: one transaction per cycle; busy is always low, the receiver cannot stall.
// Reset: arst_n clears the pipeline valids and loads taper_c0 = 1.0, other coefficients 0.
module shielded_coulomb_matrix_entry import sce_pkg::*; #(
	parameter int TAPER_TERMS = TAPER_TERMS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    command,
	input  logic [DIST_W-1:0]       distance,
	input  logic [GAM_W-1:0]        shielding_gamma,
	input  logic signed [ETA_W-1:0] self_energy,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic signed [COEF_W-1:0] cfg_data,
	output logic                    done,
	output logic signed [VAL_W-1:0] entry_value,
	output logic                    saturated
);

	localparam int TAP_LAT = 4 * (TAPER_TERMS - 1);
	localparam int ALIGN   = ROOT_LAT - TAP_LAT;
	localparam int TAG_LAT = ROOT_LAT + DIV_LAT;
	localparam int OUT_LAT = TAG_LAT + 1;

	coef_bank_t        coef_q;
	logic              accept;
	tap_t              tap_raw;
	tap_t              tap_pipe_q [ALIGN];
	tag_t              tag_pipe_q [TAG_LAT];
	tag_t              tag_out;
	tap_t              div_in;
	logic              root_vld;
	logic [ROOT_W-1:0] root_y;
	logic              div_vld;
	logic [VAL_W-1:0]  div_val;
	logic              div_sat;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= coef_bank_t'({{((NUM_COEF-1)*COEF_W){1'b0}}, COEF_ONE});
		end else if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(NUM_COEF)) begin
			coef_q[cfg_index[COEF_IDX_W-1:0]] <= cfg_data;
		end
	end

	sce_taper #(.TERMS(TAPER_TERMS)) u_taper (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (accept && command == CMD_PAIR),
		.r      (distance),
		.coef   (coef_q),
		.tap    (tap_raw)
	);

	sce_cbrt u_cbrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.r       (distance),
		.gam     (shielding_gamma),
		.out_vld (root_vld),
		.y       (root_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALIGN; i++) tap_pipe_q[i] <= '0;
			for (int i = 0; i < TAG_LAT; i++) tag_pipe_q[i] <= '0;
		end else begin
			tap_pipe_q[0] <= tap_raw;
			for (int i = 1; i < ALIGN; i++) tap_pipe_q[i] <= tap_pipe_q[i-1];
			tag_pipe_q[0] <= '{vld: accept, cmd: command, eta: self_energy};
			for (int i = 1; i < TAG_LAT; i++) tag_pipe_q[i] <= tag_pipe_q[i-1];
		end
	end

	assign div_in = '{vld: root_vld, sat: tap_pipe_q[ALIGN-1].sat,
		val: tap_pipe_q[ALIGN-1].val};

	sce_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.tap_in  (div_in),
		.y       (root_y),
		.out_vld (div_vld),
		.value   (div_val),
		.sat     (div_sat)
	);

	assign tag_out = tag_pipe_q[TAG_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done        <= 1'b0;
			entry_value <= '0;
			saturated   <= 1'b0;
		end else begin
			done <= tag_out.vld;
			if (tag_out.cmd == CMD_PAIR) begin
				entry_value <= div_val;
				saturated   <= div_sat;
			end else begin
				entry_value <= {{8{tag_out.eta[ETA_W-1]}}, tag_out.eta, 8'b0};
				saturated   <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, OUT_LAT))
		else $error("done without matching start");

	a_diag_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(command, OUT_LAT) == CMD_DIAG) |-> !saturated)
		else $error("diagonal entry flagged saturated");

	a_tag_div_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_out.vld && tag_out.cmd == CMD_PAIR) |-> div_vld)
		else $error("divider output misaligned with tag");

	a_tap_root_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		tap_pipe_q[ALIGN-1].vld |-> root_vld)
		else $error("taper output misaligned with root");
`endif

endmodule
